// ===== hw/rtl/swcrc_pkg.sv =====
// ---------------------------------------------------------------------------
// swcrc_pkg - shared definitions for the sensor word crc frame checker
// Holds field widths, the result status codes, frame positions and the
// crc-8 (poly 0x31) byte update.
// ---------------------------------------------------------------------------
package swcrc_pkg;

  // field widths
  localparam int unsigned ByteW    = 8;
  localparam int unsigned WordW    = 16;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned TempCW   = 15;
  localparam int unsigned HumCW    = 14;
  localparam int unsigned PosW     = 3;
  localparam int unsigned OutDataW = 64;

  // crc parameters
  localparam logic [ByteW-1:0] CrcInit = 8'hFF;
  localparam logic [ByteW-1:0] CrcPoly = 8'h31;

  // conversion constants
  localparam logic [WordW-1:0]  TempScale  = 16'd17500;
  localparam logic [WordW-1:0]  HumScale   = 16'd10000;
  localparam logic [TempCW-1:0] TempOffset = 15'd4500;

  // result status codes
  localparam logic [StatusW-1:0] StatusOk      = 2'd0;
  localparam logic [StatusW-1:0] StatusTempErr = 2'd1;
  localparam logic [StatusW-1:0] StatusHumErr  = 2'd2;

  // byte positions within a reply
  localparam logic [PosW-1:0] PosTempHi = 3'd0;
  localparam logic [PosW-1:0] PosTempLo = 3'd1;
  localparam logic [PosW-1:0] PosTempCrc = 3'd2;
  localparam logic [PosW-1:0] PosHumHi  = 3'd3;
  localparam logic [PosW-1:0] PosHumLo  = 3'd4;
  localparam logic [PosW-1:0] PosHumCrc = 3'd5;

  // one byte through the crc, msb first, no reflection
  function automatic logic [ByteW-1:0] crc_feed(input logic [ByteW-1:0] crc,
                                                input logic [ByteW-1:0] b);
    logic [ByteW-1:0] v;
    v = crc ^ b;
    for (int k = 0; k < ByteW; k++) begin
      if (v[ByteW-1]) begin
        v = {v[ByteW-2:0], 1'b0} ^ CrcPoly;
      end else begin
        v = {v[ByteW-2:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

// ===== hw/rtl/sensor_word_crc_frame_checker.sv =====
// ---------------------------------------------------------------------------
// sensor_word_crc_frame_checker - six-byte sensor reply checker
// Checks the crc-8 of the temperature and humidity words and converts both
// words to hundredths of a degree and hundredths of a percent.
// ---------------------------------------------------------------------------
// the request carrying the sixth byte passes the input register and then loads the result register
// throughput: one byte per cycle unless a sixth byte stalls, set by the input register and the result register
// a full result register that is not being read stalls only a sixth byte; other bytes keep flowing
// reset: frame position to idle, crc to 0xff, stored words and flags cleared,
// both registers empty
module sensor_word_crc_frame_checker
  import swcrc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [ByteW-1:0]    s_tdata,   // [7:0] data_byte
  input  logic                s_tuser,   // [0] frame_start
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OutDataW-1:0] m_tdata,   // [15:0] temperature_raw, [31:16] humidity_raw,
                                         // [46:32] temperature_centi, [60:47] humidity_centi,
                                         // [63:61] zero
  output logic [StatusW-1:0]  m_tuser    // [1:0] status
);

  // input register
  logic             in_vld_q;
  logic [ByteW-1:0] in_byte_q;
  logic             in_start_q;

  // frame state
  logic [PosW-1:0]  pos_q, pos_d;
  logic [ByteW-1:0] crc_q, crc_d;
  logic [WordW-1:0] temp_word_q, temp_word_d;
  logic             temp_ok_q, temp_ok_d;
  logic [ByteW-1:0] hum_hi_q, hum_hi_d;
  logic [ByteW-1:0] hum_lo_q, hum_lo_d;

  // result register
  logic                out_vld_q;
  logic [StatusW-1:0]  out_status_q, out_status_d;
  logic [WordW-1:0]    out_traw_q, out_traw_d;
  logic [WordW-1:0]    out_hraw_q, out_hraw_d;
  logic [TempCW-1:0]   out_tc_q, out_tc_d;
  logic [HumCW-1:0]    out_hc_q, out_hc_d;

  logic                emit;
  logic                stall;
  logic                proc;
  logic [ByteW-1:0]    crc_next;
  logic                hum_ok;
  logic [WordW-1:0]    hraw;
  logic [2*WordW-1:0]  temp_prod;
  logic [2*WordW-1:0]  hum_prod;

  // handshake: only a result-producing byte waits for the result register
  assign emit     = in_vld_q && !in_start_q && (pos_q == PosHumCrc);
  assign stall    = emit && out_vld_q && !m_tready;
  assign proc     = in_vld_q && !stall;
  assign s_tready = !in_vld_q || !stall;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      in_byte_q  <= '0;
      in_start_q <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_vld_q   <= 1'b1;
      in_byte_q  <= s_tdata;
      in_start_q <= s_tuser;
    end else if (proc) begin
      in_vld_q   <= 1'b0;
    end
  end

  // frame sequencing and crc update
  always_comb begin
    pos_d       = pos_q;
    crc_d       = crc_q;
    temp_word_d = temp_word_q;
    temp_ok_d   = temp_ok_q;
    hum_hi_d    = hum_hi_q;
    hum_lo_d    = hum_lo_q;
    crc_next    = crc_feed(in_start_q ? CrcInit : crc_q, in_byte_q);
    if (in_start_q) begin
      crc_d       = crc_next;
      temp_word_d = {in_byte_q, {ByteW{1'b0}}};
      pos_d       = PosTempLo;
    end else begin
      case (pos_q)
        PosTempLo: begin
          crc_d       = crc_next;
          temp_word_d = {temp_word_q[WordW-1:ByteW], in_byte_q};
          pos_d       = PosTempCrc;
        end
        PosTempCrc: begin
          temp_ok_d = (crc_q == in_byte_q);
          crc_d     = CrcInit;
          pos_d     = PosHumHi;
        end
        PosHumHi: begin
          crc_d    = crc_next;
          hum_hi_d = in_byte_q;
          pos_d    = PosHumLo;
        end
        PosHumLo: begin
          crc_d    = crc_next;
          hum_lo_d = in_byte_q;
          pos_d    = PosHumCrc;
        end
        PosHumCrc: begin
          crc_d = CrcInit;
          pos_d = PosTempHi;
        end
        default: begin
          pos_d = PosTempHi;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= PosTempHi;
      crc_q       <= CrcInit;
      temp_word_q <= '0;
      temp_ok_q   <= 1'b0;
      hum_hi_q    <= '0;
      hum_lo_q    <= '0;
    end else if (proc) begin
      pos_q       <= pos_d;
      crc_q       <= crc_d;
      temp_word_q <= temp_word_d;
      temp_ok_q   <= temp_ok_d;
      hum_hi_q    <= hum_hi_d;
      hum_lo_q    <= hum_lo_d;
    end
  end

  // result: status and fixed-point conversion
  assign hum_ok    = (crc_q == in_byte_q);
  assign hraw      = {hum_hi_q, hum_lo_q};
  assign temp_prod = TempScale * temp_word_q;
  assign hum_prod  = HumScale * hraw;

  always_comb begin
    out_status_d = StatusOk;
    out_traw_d   = '0;
    out_hraw_d   = '0;
    out_tc_d     = '0;
    out_hc_d     = '0;
    if (!temp_ok_q) begin
      out_status_d = StatusTempErr;
    end else if (!hum_ok) begin
      out_status_d = StatusHumErr;
    end else begin
      out_traw_d = temp_word_q;
      out_hraw_d = hraw;
      out_tc_d   = temp_prod[WordW +: TempCW] - TempOffset;
      out_hc_d   = hum_prod[WordW +: HumCW];
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q    <= 1'b0;
      out_status_q <= StatusOk;
      out_traw_q   <= '0;
      out_hraw_q   <= '0;
      out_tc_q     <= '0;
      out_hc_q     <= '0;
    end else if (proc && emit) begin
      out_vld_q    <= 1'b1;
      out_status_q <= out_status_d;
      out_traw_q   <= out_traw_d;
      out_hraw_q   <= out_hraw_d;
      out_tc_q     <= out_tc_d;
      out_hc_q     <= out_hc_d;
    end else if (m_tready) begin
      out_vld_q    <= 1'b0;
    end
  end

  assign m_tvalid = out_vld_q;
  assign m_tuser  = out_status_q;
  assign m_tdata  = {{(OutDataW - 2*WordW - TempCW - HumCW){1'b0}},
                     out_hc_q, out_tc_q, out_hraw_q, out_traw_q};

  // checks
  a_err_zero_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid && (m_tuser != StatusOk)) |-> (m_tdata == '0))
    else $error("error result carries nonzero payload");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q <= PosHumCrc))
    else $error("frame position out of range");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(proc && emit && out_vld_q && !m_tready))
    else $error("result register overwritten while held");

  a_result_follows_sixth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && emit) |=> m_tvalid)
    else $error("sixth byte gave no result");

endmodule

// ===== dv/swcrc_reading_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// swcrc_reading_checker - result checker for the sensor reply frame checker
// Watches both stream channels, rebuilds the frame walk and the crc-8 word
// checks for every accepted byte, and compares each result with the oldest
// reading still awaited.
// ---------------------------------------------------------------------------
module swcrc_reading_checker
  import swcrc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid,
  input  logic                s_tready,
  input  logic [ByteW-1:0]    s_tdata,
  input  logic                s_tuser,
  input  logic                m_tvalid,
  input  logic                m_tready,
  input  logic [OutDataW-1:0] m_tdata,
  input  logic [StatusW-1:0]  m_tuser,
  output int                  errors_o,
  output int                  awaited_o
);

  // conversion scales, hundredths of a degree and of a percent
  localparam int unsigned TempSpan  = 17500;
  localparam int          TempFloor = -4500;
  localparam int unsigned HumSpan   = 10000;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [WordW-1:0]   temp_code;
    logic [WordW-1:0]   hum_raw;
    logic [TempCW-1:0]  temp_centi;
    logic [HumCW-1:0]   hum_centi;
  } reading_t;

  reading_t         awaited_readings[$];
  logic [PosW-1:0]  bytes_taken;
  logic [ByteW-1:0] word_crc;
  logic [WordW-1:0] temp_word;
  logic             temp_crc_good;
  logic [ByteW-1:0] hum_hi;
  logic [ByteW-1:0] hum_lo;

  initial begin
    errors_o  = 0;
    awaited_o = 0;
  end

  // crc-8 poly 0x31, one data bit at a time, msb first
  function automatic logic [ByteW-1:0] crc_step(input logic [ByteW-1:0] acc,
                                                input logic [ByteW-1:0] b);
    logic [ByteW-1:0] r;
    logic             fb;
    r = acc;
    for (int i = ByteW - 1; i >= 0; i--) begin
      fb = r[ByteW-1] ^ b[i];
      r  = {r[ByteW-2:0], 1'b0} ^ (fb ? CrcPoly : '0);
    end
    return r;
  endfunction

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors_o++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
    end
  endtask

  // walk one accepted byte through the frame; the sixth byte yields a reading
  task automatic take_reply_byte(input logic [ByteW-1:0] b, input logic start);
    logic [PosW-1:0]  at;
    logic             hum_crc_good;
    logic [WordW-1:0] hum_word;
    int unsigned      prod;
    int               temp_full;
    reading_t         r;
    if (start) begin
      at = PosTempHi;
    end else begin
      // idle or impossible position: stray byte is dropped
      if (bytes_taken == PosTempHi || bytes_taken > PosHumCrc) begin
        bytes_taken = PosTempHi;
        return;
      end
      at = bytes_taken;
    end
    case (at)
      PosTempHi: begin
        word_crc  = crc_step(CrcInit, b);
        temp_word = {b, 8'h00};
      end
      PosTempLo: begin
        word_crc       = crc_step(word_crc, b);
        temp_word[7:0] = b;
      end
      PosTempCrc: begin
        temp_crc_good = (word_crc == b);
        word_crc      = CrcInit;
      end
      PosHumHi: begin
        word_crc = crc_step(word_crc, b);
        hum_hi   = b;
      end
      PosHumLo: begin
        word_crc = crc_step(word_crc, b);
        hum_lo   = b;
      end
      default: begin
        hum_crc_good = (word_crc == b);
        hum_word     = {hum_hi, hum_lo};
        bytes_taken  = PosTempHi;
        word_crc     = CrcInit;
        r            = '0;
        // temperature error wins when both words are bad
        if (!temp_crc_good) begin
          r.status = StatusTempErr;
        end else if (!hum_crc_good) begin
          r.status = StatusHumErr;
        end else begin
          r.status     = StatusOk;
          r.temp_code  = temp_word;
          r.hum_raw    = hum_word;
          prod         = TempSpan * temp_word;
          temp_full    = TempFloor + int'(prod >> 16);
          r.temp_centi = temp_full[TempCW-1:0];
          prod         = HumSpan * hum_word;
          r.hum_centi  = prod[16 +: HumCW];
        end
        awaited_readings.push_back(r);
        return;
      end
    endcase
    bytes_taken = at + 1'b1;
  endtask

  // results are checked before the byte of the same edge is taken in
  always @(posedge clk_i or negedge rst_ni) begin
    reading_t want;
    if (!rst_ni) begin
      bytes_taken   = PosTempHi;
      word_crc      = CrcInit;
      temp_word     = '0;
      temp_crc_good = 1'b0;
      hum_hi        = '0;
      hum_lo        = '0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (awaited_readings.size() == 0) begin
          errors_o++;
          $display("%0t: unexpected result, expected none actual status %0h data %0h",
                   $time, m_tuser, m_tdata);
        end else begin
          want = awaited_readings.pop_front();
          check_field("status", 32'(want.status), 32'(m_tuser));
          check_field("temperature_raw", 32'(want.temp_code), 32'(m_tdata[15:0]));
          check_field("humidity_raw", 32'(want.hum_raw), 32'(m_tdata[31:16]));
          check_field("temperature_centi", 32'(want.temp_centi), 32'(m_tdata[46:32]));
          check_field("humidity_centi", 32'(want.hum_centi), 32'(m_tdata[60:47]));
          check_field("padding", 32'd0, 32'(m_tdata[63:61]));
        end
      end
      if (s_tvalid && s_tready) begin
        take_reply_byte(s_tdata, s_tuser);
      end
    end
    awaited_o = awaited_readings.size();
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb - testbench top for the sensor word crc frame checker
// Builds sensor replies (clean, with bad word crcs, cut short, stray bytes),
// feeds them in bursts while the result side stalls, and reports the verdict
// from the count kept by the reading checker.
// ---------------------------------------------------------------------------
module tb
  import swcrc_pkg::*;
();

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned ReplyTarget = 1150;
  localparam int unsigned HoldStart   = 400;
  localparam int unsigned HoldLen     = 300;
  localparam int unsigned TailCycles  = 8;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             start;
  } reply_byte_t;

  typedef enum logic [1:0] {SinkOpen, SinkCoin, SinkSparse, SinkPulse} sink_mode_e;

  logic                clk_i;
  logic                rst_ni   = 1'b0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [ByteW-1:0]    s_tdata  = '0;
  logic                s_tuser  = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic [StatusW-1:0]  m_tuser;
  int                  errors;
  int                  awaited;

  reply_byte_t reply_bytes[$];
  int unsigned reply_items = 0;

  sensor_word_crc_frame_checker dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  swcrc_reading_checker reading_check (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .errors_o (errors),
    .awaited_o(awaited)
  );

  // 100 MHz clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // check byte of a whole word, 16 bits shifted through from 0xff
  function automatic logic [ByteW-1:0] word_check(input logic [WordW-1:0] w);
    logic [ByteW-1:0] c;
    c = CrcInit;
    for (int i = WordW - 1; i >= 0; i--) begin
      c = (c[ByteW-1] ^ w[i]) ? ({c[ByteW-2:0], 1'b0} ^ CrcPoly) : {c[ByteW-2:0], 1'b0};
    end
    return c;
  endfunction

  function automatic logic [WordW-1:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return WordW'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic push_byte(input logic [ByteW-1:0] d, input logic start);
    reply_byte_t rb;
    rb.data  = d;
    rb.start = start;
    reply_bytes.push_back(rb);
  endtask

  // queue the first n bytes of a reply, corrupting either check byte on request
  task automatic push_reply(input logic [WordW-1:0] t, input logic [WordW-1:0] h,
                            input bit temp_bad, input bit hum_bad, input int n);
    logic [ByteW-1:0] frame[6];
    frame[0] = t[15:8];
    frame[1] = t[7:0];
    frame[2] = word_check(t) ^ (temp_bad ? ByteW'($urandom_range(1, 255)) : '0);
    frame[3] = h[15:8];
    frame[4] = h[7:0];
    frame[5] = word_check(h) ^ (hum_bad ? ByteW'($urandom_range(1, 255)) : '0);
    for (int i = 0; i < n; i++) begin
      push_byte(frame[i], i == 0);
    end
    reply_items += n;
  endtask

  // directed replies, then random ones
  task automatic build_replies();
    int          kind;
    int          flaw;
    int          n;
    logic [15:0] t;
    logic [15:0] h;
    // stray byte while idle, then word extremes and each status
    push_byte(8'hA5, 1'b0);
    push_reply(16'h0000, 16'hFFFF, 0, 0, 6);
    push_reply(16'hFFFF, 16'h0000, 0, 0, 6);
    push_reply(16'h6666, 16'h8000, 1, 1, 6);
    // reply cut short by a new start flag
    push_reply(16'h1234, 16'h5678, 0, 0, 2);
    push_reply(16'h8000, 16'h7FFF, 0, 1, 6);
    while (reply_items < ReplyTarget) begin
      kind = $urandom_range(0, 99);
      flaw = $urandom_range(0, 9);
      t    = pick_word();
      h    = pick_word();
      if (kind < 72) begin
        push_reply(t, h, flaw == 0 || flaw == 2, flaw == 1 || flaw == 2, 6);
      end else if (kind < 87) begin
        push_reply(t, h, flaw == 0, flaw == 1, $urandom_range(1, 5));
      end else if (kind < 94) begin
        push_reply(t, h, flaw == 0, flaw == 1, 6);
        n = $urandom_range(1, 3);
        repeat (n) push_byte(ByteW'($urandom_range(0, 255)), 1'b0);
      end else begin
        // noise with random start flags
        n = $urandom_range(1, 4);
        repeat (n) push_byte(ByteW'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        reply_items += n;
      end
    end
  endtask

  // request side: bursts of random length with random gaps
  initial begin : stimulus
    int          burst_left;
    int          gap;
    reply_byte_t rb;
    burst_left = 0;
    build_replies();
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    while (reply_bytes.size() > 0) begin
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120) :
                                                   $urandom_range(1, 20);
        gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          s_tvalid <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
      end
      rb = reply_bytes.pop_front();
      s_tvalid <= 1'b1;
      s_tdata  <= rb.data;
      s_tuser  <= rb.start;
      @(posedge clk_i);
      while (!s_tready) @(posedge clk_i);
      @(negedge clk_i);
      burst_left--;
    end
    s_tvalid <= 1'b0;
    while (awaited != 0) @(negedge clk_i);
    repeat (TailCycles) @(negedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // result side: changing stall patterns plus one long hold-off
  initial begin : result_sink
    int unsigned sink_cycles;
    int          mode_left;
    sink_mode_e  mode;
    sink_cycles = 0;
    mode_left   = 0;
    mode        = SinkOpen;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      sink_cycles++;
      if (mode_left == 0) begin
        mode      = sink_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      if (sink_cycles >= HoldStart && sink_cycles < HoldStart + HoldLen) begin
        m_tready <= 1'b0;
      end else begin
        case (mode)
          SinkOpen:   m_tready <= 1'b1;
          SinkCoin:   m_tready <= 1'($urandom_range(0, 1));
          SinkSparse: m_tready <= ($urandom_range(0, 3) == 0);
          default:    m_tready <= sink_cycles[2];
        endcase
      end
    end
  end

  // run limit
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/swcrc_pkg.sv
hw/rtl/sensor_word_crc_frame_checker.sv
dv/swcrc_reading_checker.sv
dv/tb.sv
